/* hdl/swk_pkg.sv */
// swk_pkg: shared types, constants and tables of the swerve wheel kinematics block
// used by swk_front, swk_cordic, swk_back and swerve_wheel_kinematics_top
// no dependencies
package swk_pkg;

    // sizes
    localparam int WHEEL_COUNT       = 4;
    localparam int WHEEL_W           = 2;
    localparam int CORDIC_ITERATIONS = 16;
    localparam int ATAN_ENTRIES      = 24;
    localparam int ITER_COUNT        = (CORDIC_ITERATIONS < ATAN_ENTRIES) ?
                                       CORDIC_ITERATIONS : ATAN_ENTRIES;
    localparam int ITER_W            = 5;
    localparam int CX_W              = 36;
    localparam int CZ_W              = 32;

    // fixed-point constants
    localparam int GAIN_Q16    = 39797;
    localparam int SPEED_MAX   = 65535;
    localparam int ANGLE_MAX   = 54000;
    localparam int ARM_DIVISOR = 1000;
    localparam int ARM_RESET   = 848;

    // divide by 1000 as a reciprocal multiply: |yaw * arm| stays below 2^44,
    // and ceil(2^53 / 1000) * 1000 exceeds 2^53 by only 8, so the floor is exact
    localparam int DIV_W       = 44;
    localparam int DIV_HALF    = 22;
    localparam int DIV_STEPS   = 4;
    localparam int ACC_W       = 88;
    localparam int RECIP_SHIFT = 53;
    localparam logic [DIV_W-1:0] RECIP_M =
        DIV_W'(((64'd1 << RECIP_SHIFT) + 64'(ARM_DIVISOR) - 64'd1) / 64'(ARM_DIVISOR));

    // configuration register indexes
    localparam logic REG_ARM_LENGTH     = 1'b0;
    localparam logic REG_HEADING_ORIGIN = 1'b1;

    // drive modes
    localparam logic [1:0] MODE_MMPS = 2'd1;
    localparam logic [1:0] MODE_RPM  = 2'd2;

    // classified command handed from front to back
    typedef struct packed {
        logic signed [13:0] vel_x;
        logic signed [13:0] vel_y;
        logic signed [15:0] yaw_rate;
        logic signed [17:0] rel_heading;
        logic               upd;
        logic               rpm;
        logic               rev;
    } cmd_t;

    // cordic control and status
    typedef struct packed {
        logic start;
        logic vec_mode;
    } cordic_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } cordic_sts_t;

    // atan(2^-i) in Q16 centidegrees
    function automatic logic [29:0] atan_q16(input logic [ITER_W-1:0] idx);
        case (idx)
            5'd0:    atan_q16 = 30'd294912000;
            5'd1:    atan_q16 = 30'd174096719;
            5'd2:    atan_q16 = 30'd91987925;
            5'd3:    atan_q16 = 30'd46694507;
            5'd4:    atan_q16 = 30'd23437865;
            5'd5:    atan_q16 = 30'd11730358;
            5'd6:    atan_q16 = 30'd5866611;
            5'd7:    atan_q16 = 30'd2933484;
            5'd8:    atan_q16 = 30'd1466764;
            5'd9:    atan_q16 = 30'd733385;
            5'd10:   atan_q16 = 30'd366693;
            5'd11:   atan_q16 = 30'd183346;
            5'd12:   atan_q16 = 30'd91673;
            5'd13:   atan_q16 = 30'd45837;
            5'd14:   atan_q16 = 30'd22918;
            5'd15:   atan_q16 = 30'd11459;
            5'd16:   atan_q16 = 30'd5730;
            5'd17:   atan_q16 = 30'd2865;
            5'd18:   atan_q16 = 30'd1432;
            5'd19:   atan_q16 = 30'd716;
            5'd20:   atan_q16 = 30'd358;
            5'd21:   atan_q16 = 30'd179;
            5'd22:   atan_q16 = 30'd90;
            5'd23:   atan_q16 = 30'd45;
            default: atan_q16 = 30'd0;
        endcase
    endfunction

    // arm mounting angle per wheel, centidegrees
    function automatic logic signed [17:0] arm_base_cd(input logic [WHEEL_W-1:0] w);
        case (w)
            2'd0:    arm_base_cd = -18'sd4500;
            2'd1:    arm_base_cd = 18'sd4500;
            2'd2:    arm_base_cd = 18'sd13500;
            default: arm_base_cd = -18'sd13500;
        endcase
    endfunction

endpackage

/* hdl/swerve_wheel_kinematics_top.sv */
// swerve_wheel_kinematics_top: four-wheel swerve inverse kinematics, top level
// depends on swk_pkg, swk_front, swk_back (which holds swk_cordic)
//
//  channel   ports                     payload
//  input     s_tvalid/s_tready         s_tdata (vel_x, vel_y, yaw_rate_cmd, heading_now),
//                                      s_tuser (drive_mode)
//  result    m_tvalid/m_tready         m_tdata (angle_w0..3, speed_w0..3)
//  config    cfg_we/cfg_addr           cfg_wdata (arm_length_mm, heading_origin)
//
// each command runs through the back end as four wheel passes, made of one shared cordic
// (one pass for the arm, one for the wheel vector), a reciprocal multiply for the
// divide by 1000 and the wrap steps; a zero wheel vector skips the second cordic pass,
// and pickup, reverse and output each have their own state
// a two-entry queue takes up to two further commands while one is at work
// synchronous active-low reset; wheel stores clear to zero, arm length 848, origin 0
// a result waiting in the output register holds the back end before its next result
module swerve_wheel_kinematics_top (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [63:0]   s_tdata,    // vel_x[13:0], vel_y[27:14], yaw_rate_cmd[43:28],
                                      // heading_now[59:44], zero fill
    input  logic [1:0]    s_tuser,    // drive_mode[1:0]
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [135:0]  m_tdata,    // angle_w0..angle_w3 [67:0], speed_w0..speed_w3 [135:68]
    input  logic          cfg_we,
    input  logic          cfg_addr,
    input  logic [15:0]   cfg_wdata
);
    import swk_pkg::*;

    logic [10:0]        arm_len_reg;
    logic signed [15:0] origin_reg;
    logic               q_valid, q_pop;
    cmd_t               q_data;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arm_len_reg <= 11'(ARM_RESET);
            origin_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_ARM_LENGTH:     arm_len_reg <= cfg_wdata[10:0];
                REG_HEADING_ORIGIN: origin_reg  <= cfg_wdata;
                default:            arm_len_reg <= arm_len_reg;
            endcase
        end
    end

    swk_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .heading_origin (origin_reg),
        .q_valid        (q_valid),
        .q_data         (q_data),
        .q_pop          (q_pop)
    );

    swk_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .arm_length_mm (arm_len_reg),
        .q_valid       (q_valid),
        .q_data        (q_data),
        .q_pop         (q_pop),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata)
    );

endmodule

/* hdl/swk_front.sv */
// swk_front: input acceptance, command classification and a two-entry queue
// depends on swk_pkg
module swk_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [63:0]         s_tdata,   // vel_x[13:0], vel_y[27:14], yaw_rate_cmd[43:28],
                                           // heading_now[59:44], zero fill
    input  logic [1:0]          s_tuser,   // drive_mode[1:0]
    input  logic signed [15:0]  heading_origin,
    output logic                q_valid,
    output swk_pkg::cmd_t       q_data,
    input  logic                q_pop
);
    import swk_pkg::*;

    cmd_t       q_mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    cmd_t       cmd_new;
    logic signed [15:0] hd;

    // classify the incoming command
    always_comb begin
        hd                  = s_tdata[59:44];
        cmd_new.vel_x       = s_tdata[13:0];
        cmd_new.vel_y       = s_tdata[27:14];
        cmd_new.yaw_rate    = s_tdata[43:28];
        cmd_new.rel_heading = 18'(hd) - 18'(heading_origin);
        cmd_new.upd         = (s_tuser == MODE_MMPS) || (s_tuser == MODE_RPM);
        cmd_new.rpm         = (s_tuser == MODE_RPM);
        cmd_new.rev         = s_tdata[13] && (s_tdata[27:14] == 14'd0);
    end

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_data   = q_mem[rd_ptr_reg];

    // queue pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(q_pop);
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= cmd_new;
        end
    end

`ifndef SYNTH
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("queue count out of range");
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> count_reg != 2'd0)
        else $error("queue popped while empty");
`endif

endmodule

/* hdl/swk_cordic.sv */
// swk_cordic: iterative cordic, one micro-rotation per cycle, rotation or vectoring
// depends on swk_pkg
module swk_cordic (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  swk_pkg::cordic_req_t   req,
    input  logic signed [35:0]     x_in,
    input  logic signed [35:0]     y_in,
    input  logic signed [31:0]     z_in,
    output swk_pkg::cordic_sts_t   sts,
    output logic signed [35:0]     x_out,
    output logic signed [35:0]     y_out,
    output logic signed [31:0]     z_out
);
    import swk_pkg::*;

    logic signed [CX_W-1:0] x_reg, y_reg;
    logic signed [CZ_W-1:0] z_reg;
    logic [ITER_W-1:0]      iter_reg;
    logic                   busy_reg, done_reg, vec_reg;
    logic signed [CX_W-1:0] dx, dy, x_next, y_next;
    logic signed [CZ_W-1:0] ang, z_next;
    logic                   go_minus;

    // one micro-rotation
    always_comb begin
        dx       = y_reg >>> iter_reg;
        dy       = x_reg >>> iter_reg;
        ang      = $signed(CZ_W'(atan_q16(iter_reg)));
        go_minus = vec_reg ? y_reg[CX_W-1] : ~z_reg[CZ_W-1];
        if (go_minus) begin
            x_next = x_reg - dx;
            y_next = y_reg + dy;
            z_next = z_reg - ang;
        end else begin
            x_next = x_reg + dx;
            y_next = y_reg - dy;
            z_next = z_reg + ang;
        end
    end

    // iteration control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                iter_reg <= '0;
            end else if (busy_reg) begin
                iter_reg <= iter_reg + 1'b1;
                if (iter_reg == ITER_W'(ITER_COUNT - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (req.start) begin
            x_reg   <= x_in;
            y_reg   <= y_in;
            z_reg   <= z_in;
            vec_reg <= req.vec_mode;
        end else if (busy_reg) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;

`ifndef SYNTH
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !busy_reg)
        else $error("cordic started while busy");
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg && !busy_reg)
        else $error("cordic done not a single pulse");
`endif

endmodule

/* hdl/swk_back.sv */
// swk_back: per-wheel sequencer, arm products, divide by 1000, wheel stores, output register
// depends on swk_pkg and swk_cordic
module swk_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [10:0]         arm_length_mm,
    input  logic                q_valid,
    input  swk_pkg::cmd_t       q_data,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [135:0]        m_tdata
);
    import swk_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_WRAP, S_FOLD, S_ROT, S_MUL, S_DINIT, S_DIV, S_VPREP,
        S_VSTART, S_VEC, S_GLO, S_GHI, S_FIN, S_REV, S_OUT
    } state_t;

    state_t                 state_reg;
    cmd_t                   cmd_reg;
    logic [WHEEL_W-1:0]     wheel_reg;
    logic signed [17:0]     theta_reg;
    logic                   neg_reg;
    logic signed [29:0]     ax_reg, ay_reg;
    logic signed [45:0]     px_reg, py_reg;
    logic [DIV_W-1:0]       nx_reg, ny_reg;
    logic [ACC_W-1:0]       accx_reg, accy_reg;
    logic                   sx_reg, sy_reg;
    logic [ITER_W-1:0]      step_reg;
    logic signed [35:0]     ux_reg, uy_reg;
    logic signed [15:0]     base_reg;
    logic signed [17:0]     zang_reg;
    logic [35:0]            mag_reg;
    logic [33:0]            glo_reg;
    logic signed [16:0]     angle_store [WHEEL_COUNT];
    logic signed [16:0]     speed_store [WHEEL_COUNT];
    logic [135:0]           m_tdata_reg;
    logic                   m_tvalid_reg;

    cordic_req_t            creq;
    cordic_sts_t            csts;
    logic signed [35:0]     cx_in, cy_in, cx_out, cy_out;
    logic signed [31:0]     cz_in, cz_out;

    // fold and rotation setup
    logic signed [17:0]     fold_t;
    logic                   fold_neg;
    // reciprocal multiply partial products
    logic [DIV_HALF-1:0]    m_half, nx_half, ny_half;
    logic [DIV_W-1:0]       pmx, pmy;
    logic [ACC_W-1:0]       ppx, ppy;
    // vector setup and finish
    logic signed [35:0]     qxs, qys;
    logic                   vzero, vneg;
    logic signed [31:0]     zr;
    logic [51:0]            gfull;
    logic signed [18:0]     ang_full;
    logic signed [16:0]     ang_sat;
    logic [41:0]            m42, rpm_sum;
    logic [36:0]            mm_sum;
    logic [21:0]            spd_raw;
    logic signed [16:0]     spd_sat;
    logic                   out_free;

    swk_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (creq),
        .x_in    (cx_in),
        .y_in    (cy_in),
        .z_in    (cz_in),
        .sts     (csts),
        .x_out   (cx_out),
        .y_out   (cy_out),
        .z_out   (cz_out)
    );

    // fold arm angle into [-90, 90] degrees
    always_comb begin
        fold_t   = theta_reg;
        fold_neg = 1'b0;
        if (theta_reg > 18'sd9000) begin
            fold_t   = theta_reg - 18'sd18000;
            fold_neg = 1'b1;
        end else if (theta_reg < -18'sd9000) begin
            fold_t   = theta_reg + 18'sd18000;
            fold_neg = 1'b1;
        end
    end

    // wheel vector and vectoring setup
    always_comb begin
        qxs   = sx_reg ? -$signed({1'b0, accx_reg[ACC_W-1:RECIP_SHIFT]})
                       : $signed({1'b0, accx_reg[ACC_W-1:RECIP_SHIFT]});
        qys   = sy_reg ? -$signed({1'b0, accy_reg[ACC_W-1:RECIP_SHIFT]})
                       : $signed({1'b0, accy_reg[ACC_W-1:RECIP_SHIFT]});
        vzero = (ux_reg == 36'sd0) && (uy_reg == 36'sd0);
        vneg  = ux_reg[35];
    end

    // cordic requests
    always_comb begin
        creq.start    = 1'b0;
        creq.vec_mode = 1'b0;
        cx_in         = 36'(arm_length_mm) * 36'(GAIN_Q16);
        cy_in         = 36'sd0;
        cz_in         = 32'(fold_t) <<< 16;
        if (state_reg == S_FOLD) begin
            creq.start = 1'b1;
        end else if (state_reg == S_VSTART) begin
            creq.start    = !vzero;
            creq.vec_mode = 1'b1;
            cx_in         = vneg ? -ux_reg : ux_reg;
            cy_in         = vneg ? -uy_reg : uy_reg;
            cz_in         = 32'sd0;
        end
    end

    // one 22x22 partial product of |p| * reciprocal per cycle for each axis
    always_comb begin
        m_half  = step_reg[0] ? RECIP_M[DIV_W-1:DIV_HALF] : RECIP_M[DIV_HALF-1:0];
        nx_half = step_reg[1] ? nx_reg[DIV_W-1:DIV_HALF] : nx_reg[DIV_HALF-1:0];
        ny_half = step_reg[1] ? ny_reg[DIV_W-1:DIV_HALF] : ny_reg[DIV_HALF-1:0];
        pmx     = DIV_W'(nx_half) * DIV_W'(m_half);
        pmy     = DIV_W'(ny_half) * DIV_W'(m_half);
        ppx     = ACC_W'(pmx);
        ppy     = ACC_W'(pmy);
        if (step_reg[1:0] == 2'd3) begin
            ppx = ppx << (2 * DIV_HALF);
            ppy = ppy << (2 * DIV_HALF);
        end else if (step_reg[1:0] != 2'd0) begin
            ppx = ppx << DIV_HALF;
            ppy = ppy << DIV_HALF;
        end
    end

    // angle and speed of the finished wheel
    always_comb begin
        zr       = (cz_out + 32'sd32768) >>> 16;
        gfull    = (52'(cx_out[35:18]) * 52'(GAIN_Q16) << 18) + 52'(glo_reg);
        ang_full = 19'(zang_reg) - 19'(cmd_reg.rel_heading);
        if (ang_full > 19'(ANGLE_MAX)) begin
            ang_sat = 17'(ANGLE_MAX);
        end else if (ang_full < -19'(ANGLE_MAX)) begin
            ang_sat = -17'(ANGLE_MAX);
        end else begin
            ang_sat = ang_full[16:0];
        end
        m42     = 42'(mag_reg);
        rpm_sum = (m42 << 6) - (m42 << 3) + m42 + 42'd524288;
        mm_sum  = 37'(mag_reg) + 37'd32768;
        if (cmd_reg.rpm) begin
            spd_raw = 22'(rpm_sum >> 20);
        end else begin
            spd_raw = 22'(mm_sum >> 16);
        end
        if (spd_raw > 22'(SPEED_MAX)) begin
            spd_sat = 17'(SPEED_MAX);
        end else begin
            spd_sat = $signed(spd_raw[16:0]);
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;
    assign q_pop    = (state_reg == S_IDLE) && q_valid;

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            wheel_reg    <= '0;
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < WHEEL_COUNT; i++) begin
                angle_store[i] <= '0;
                speed_store[i] <= '0;
            end
        end else begin
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        cmd_reg   <= q_data;
                        wheel_reg <= '0;
                        theta_reg <= q_data.rel_heading + arm_base_cd('0);
                        state_reg <= S_WRAP;
                    end
                end
                S_WRAP: begin
                    if (theta_reg >= 18'sd18000) begin
                        theta_reg <= theta_reg - 18'sd36000;
                    end else if (theta_reg < -18'sd18000) begin
                        theta_reg <= theta_reg + 18'sd36000;
                    end else begin
                        state_reg <= S_FOLD;
                    end
                end
                S_FOLD: begin
                    neg_reg   <= fold_neg;
                    state_reg <= S_ROT;
                end
                S_ROT: begin
                    if (csts.done) begin
                        ax_reg    <= neg_reg ? -cx_out[29:0] : cx_out[29:0];
                        ay_reg    <= neg_reg ? -cy_out[29:0] : cy_out[29:0];
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    px_reg    <= 46'(cmd_reg.yaw_rate) * 46'(ay_reg);
                    py_reg    <= 46'(cmd_reg.yaw_rate) * 46'(ax_reg);
                    state_reg <= S_DINIT;
                end
                S_DINIT: begin
                    sx_reg    <= px_reg[45];
                    sy_reg    <= py_reg[45];
                    nx_reg    <= px_reg[45] ? DIV_W'(-px_reg) : DIV_W'(px_reg);
                    ny_reg    <= py_reg[45] ? DIV_W'(-py_reg) : DIV_W'(py_reg);
                    accx_reg  <= '0;
                    accy_reg  <= '0;
                    step_reg  <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    accx_reg <= accx_reg + ppx;
                    accy_reg <= accy_reg + ppy;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == ITER_W'(DIV_STEPS - 1)) begin
                        state_reg <= S_VPREP;
                    end
                end
                S_VPREP: begin
                    ux_reg    <= (36'(cmd_reg.vel_x) <<< 16) + qxs;
                    uy_reg    <= (36'(cmd_reg.vel_y) <<< 16) - qys;
                    state_reg <= S_VSTART;
                end
                S_VSTART: begin
                    if (vzero) begin
                        zang_reg  <= '0;
                        mag_reg   <= '0;
                        state_reg <= S_FIN;
                    end else begin
                        if (!vneg) begin
                            base_reg <= 16'sd0;
                        end else if (!uy_reg[35]) begin
                            base_reg <= 16'sd18000;
                        end else begin
                            base_reg <= -16'sd18000;
                        end
                        state_reg <= S_VEC;
                    end
                end
                S_VEC: begin
                    if (csts.done) begin
                        zang_reg  <= 18'(base_reg) + zr[17:0];
                        state_reg <= S_GLO;
                    end
                end
                S_GLO: begin
                    glo_reg   <= 34'(cx_out[17:0]) * 34'(GAIN_Q16);
                    state_reg <= S_GHI;
                end
                S_GHI: begin
                    mag_reg   <= gfull[51:16];
                    state_reg <= S_FIN;
                end
                S_FIN: begin
                    if (cmd_reg.upd) begin
                        angle_store[wheel_reg] <= ang_sat;
                        speed_store[wheel_reg] <= spd_sat;
                    end
                    if (wheel_reg == WHEEL_W'(WHEEL_COUNT - 1)) begin
                        state_reg <= S_REV;
                    end else begin
                        wheel_reg <= wheel_reg + 1'b1;
                        theta_reg <= cmd_reg.rel_heading + arm_base_cd(wheel_reg + 1'b1);
                        state_reg <= S_WRAP;
                    end
                end
                S_REV: begin
                    if (cmd_reg.rev) begin
                        for (int i = 0; i < WHEEL_COUNT; i++) begin
                            angle_store[i] <= '0;
                            speed_store[i] <= -speed_store[i];
                        end
                    end
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        m_tdata_reg  <= {speed_store[3], speed_store[2], speed_store[1],
                                         speed_store[0], angle_store[3], angle_store[2],
                                         angle_store[1], angle_store[0]};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTH
    a_rev_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && cmd_reg.rev) |->
        (angle_store[0] == 17'sd0 && angle_store[1] == 17'sd0 &&
         angle_store[2] == 17'sd0 && angle_store[3] == 17'sd0))
        else $error("reverse left a steer angle set");
    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> step_reg < ITER_W'(DIV_STEPS))
        else $error("divider step count overrun");
`endif

endmodule
